// ===== src/flkh_pkg.sv =====
// Shared constants and types for the feature list key hash.
package flkh_pkg;

   localparam int unsigned HASH_WIDTH   = 64;
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned SHIFT_WIDTH  = 96;

   localparam logic [HASH_WIDTH-1:0] HASH_SEED      = 64'hCBF29CE484222325;
   // prime = 2^40 + 0x1B3
   localparam logic [8:0]           FNV_PRIME_LOW    = 9'h1B3;
   localparam int unsigned          FNV_PRIME_SHIFT  = 40;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_FEATURE = 1'b1;

   localparam logic [3:0] START_BYTES   = 4'd4;
   localparam logic [3:0] FEATURE_BYTES = 4'd12;

   typedef struct packed {
      logic load;
      logic start;
      logic step;
   } flkh_ctl_type;

endpackage

// ===== src/flkh_byte_shifter.sv =====
// Byte shift register that feeds the item's bytes to the hash round, low byte first.
module flkh_byte_shifter (
   input  logic                  clock,
   input  flkh_pkg::flkh_ctl_type ctl,
   input  logic [7:0]            feature_count,
   input  logic [63:0]           feature_id,
   input  logic [31:0]           feature_value,
   output logic [7:0]            data_byte
);
   import flkh_pkg::*;

   logic [SHIFT_WIDTH-1:0] data_ff;
   logic [SHIFT_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         if (ctl.start) begin
            data_in = {{(SHIFT_WIDTH-8){1'b0}}, feature_count};
         end else begin
            data_in = {feature_value, feature_id};
         end
      end else if (ctl.step) begin
         data_in = {{BYTE_WIDTH{1'b0}}, data_ff[SHIFT_WIDTH-1:BYTE_WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_byte = data_ff[BYTE_WIDTH-1:0];

endmodule

// ===== src/flkh_hash_round.sv =====
// Running hash register with one FNV-1a byte round per step.
module flkh_hash_round (
   input  logic                  clock,
   input  logic                  reset,
   input  flkh_pkg::flkh_ctl_type ctl,
   input  logic [7:0]            data_byte,
   output logic [63:0]           hash
);
   import flkh_pkg::*;

   logic [HASH_WIDTH-1:0] hash_ff;
   logic [HASH_WIDTH-1:0] hash_in;
   logic [HASH_WIDTH-1:0] mixed;
   logic [HASH_WIDTH+8:0] low_prod;

   always_comb begin
      mixed    = hash_ff ^ {{(HASH_WIDTH-BYTE_WIDTH){1'b0}}, data_byte};
      low_prod = (HASH_WIDTH+9)'(mixed) * (HASH_WIDTH+9)'(FNV_PRIME_LOW);
      hash_in  = hash_ff;
      if (ctl.load && ctl.start) begin
         hash_in = HASH_SEED;
      end else if (ctl.step) begin
         hash_in = low_prod[HASH_WIDTH-1:0] + (mixed << FNV_PRIME_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_SEED;
      end else begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ===== src/feature_list_key_hash.sv =====
// FNV-1a 64-bit key over a framed feature list. The block takes one item at a time and
// hashes it one byte per cycle: a begin item loads the offset basis and runs 4 byte
// rounds on the count, a feature item runs 12 rounds on the id and the value. Input
// stays stalled while the single shared byte round runs them and while a key is pending.
// An item with last set raises the pending flag on its final round, and the key then
// moves from the running hash into the output register; if an earlier key is still
// waiting there, input stays stalled until that key is taken. The running hash stays
// after a key is sent.
module feature_list_key_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_feature_count,
   input  logic [63:0] req_feature_id,
   input  logic [31:0] req_feature_value,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_variant_key
);
   import flkh_pkg::*;

   flkh_ctl_type          ctl;
   logic [7:0]            data_byte;
   logic [HASH_WIDTH-1:0] hash;

   logic [3:0]            count_ff;
   logic [3:0]            count_in;
   logic                  last_ff;
   logic                  last_in;
   logic                  pend_ff;
   logic                  pend_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [HASH_WIDTH-1:0] rsp_key_ff;
   logic [HASH_WIDTH-1:0] rsp_key_in;
   logic                  busy;
   logic                  accept;
   logic                  release_key;

   assign busy      = (count_ff != 4'd0);
   assign req_stall = busy | pend_ff;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      ctl.load  = accept;
      ctl.start = (req_operation == OP_START);
      ctl.step  = busy;
   end

   flkh_byte_shifter u_shifter (
      .clock         (clock),
      .ctl           (ctl),
      .feature_count (req_feature_count),
      .feature_id    (req_feature_id),
      .feature_value (req_feature_value),
      .data_byte     (data_byte)
   );

   flkh_hash_round u_round (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .data_byte (data_byte),
      .hash      (hash)
   );

   always_comb begin
      release_key  = pend_ff & (~rsp_valid_ff | ~rsp_stall);
      count_in     = count_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;

      if (accept) begin
         count_in = (req_operation == OP_FEATURE) ? FEATURE_BYTES : START_BYTES;
         last_in  = req_last;
      end else if (busy) begin
         count_in = count_ff - 4'd1;
         if (count_ff == 4'd1 && last_ff) begin
            pend_in = 1'b1;
         end
      end

      if (release_key) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_key_in   = hash;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 4'd0;
         last_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_key_ff <= rsp_key_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_variant_key = rsp_key_ff;

endmodule
